[rtl/core/indexed_list_insert_remove_macros.svh]
// Assertion macros for the indexed list block.
`ifndef INDEXED_LIST_INSERT_REMOVE_MACROS_SVH
`define INDEXED_LIST_INSERT_REMOVE_MACROS_SVH
`ifndef SYNTHESIS
`define ILIR_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
`define ILIR_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
`define ILIR_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define ILIR_ASSERT(lbl, prop, msg)
`define ILIR_ASSERT_IMPL(lbl, ante, cons, msg)
`define ILIR_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

[rtl/core/ilir_pkg.sv]
// Types and constants shared by the indexed list cells and top level.
`timescale 1ns / 1ps
package ilir_pkg;

   localparam int VALUE_W    = 32;
   localparam int POSITION_W = 6;
   // clamped position is non-negative, so the sign bit drops
   localparam int POS_W      = POSITION_W - 1;
   localparam int STATUS_W   = 2;
   localparam int DEF_CAPACITY = 16;

   typedef enum logic [1:0] {
      OP_READ   = 2'd0,
      OP_INSERT = 2'd1,
      OP_REMOVE = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_RANGE = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CELL_HOLD   = 2'd0,
      CELL_INSERT = 2'd1,
      CELL_REMOVE = 2'd2
   } cell_op_type;

endpackage

[rtl/core/indexed_list_insert_remove.sv]
// Indexed ordered list with read, insert and remove by position.
// Usage:
//   Request channel (req_valid/req_ready) carries op, position and value.
//   Each item yields exactly one result on the rsp_ channel: read value,
//   element count, empty flag and status.
//   Storage is a chain of CAPACITY cells; on an insert every cell past the
//   position takes its left neighbor and the cell at it takes the new value,
//   on a remove every cell at or past it takes its right neighbor, all at
//   the same clock edge, so items may arrive every cycle while rsp_ready is high.
//   The read path is an OR over all cells selected by position.
//   The result is registered and valid the cycle after the item is accepted.
//   Throughput: 1 item per cycle while rsp_ready is high.
//   If the receiver stalls, the output register holds the result and
//   req_ready drops until it is taken; nothing is lost.
//   Reset: synchronous, active high; the list becomes empty and no result
//   is pending. Cell contents are not cleared; unused slots are never read.
`timescale 1ns / 1ps
`include "indexed_list_insert_remove_macros.svh"
module indexed_list_insert_remove
   import ilir_pkg::*;
#(
   parameter int CAPACITY = DEF_CAPACITY,
   localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [1:0]                   req_op,
   input  logic signed [POSITION_W-1:0] req_position,
   input  logic signed [VALUE_W-1:0]    req_value,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [VALUE_W-1:0]    rsp_read_value,
   output logic [CNT_W-1:0]             rsp_element_count,
   output logic                         rsp_is_empty,
   output logic [STATUS_W-1:0]          rsp_status
);

   localparam int IDX_W = (POS_W > $clog2(CAPACITY)) ? POS_W : $clog2(CAPACITY);
   localparam int CMP_W = (POS_W > CNT_W) ? POS_W : CNT_W;

   logic [CNT_W-1:0]    count_ff, count_in;
   logic                rsp_valid_ff;
   logic [VALUE_W-1:0]  rd_value_ff, rd_value_in;
   logic [STATUS_W-1:0] status_ff;
   status_type          status_in;
   logic [CNT_W-1:0]    rsp_count_ff;
   logic                accept;
   logic [POS_W-1:0]    pos_clamp;
   logic                in_range;
   logic                full;
   logic [VALUE_W-1:0]  rd_any;
   cell_op_type         ctl_op;
   logic [IDX_W-1:0]    ctl_pos;

   logic [VALUE_W-1:0]  cell_value [CAPACITY];
   logic [VALUE_W-1:0]  cell_rd    [CAPACITY];

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   assign pos_clamp = req_position[POSITION_W-1] ? '0 : req_position[POS_W-1:0];
   assign in_range  = CMP_W'(pos_clamp) < CMP_W'(count_ff);
   assign full      = count_ff == CNT_W'(CAPACITY);

   always_comb begin
      rd_any = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         rd_any = rd_any | cell_rd[i];
      end
   end

   always_comb begin
      ctl_op      = CELL_HOLD;
      ctl_pos     = IDX_W'(pos_clamp);
      count_in    = count_ff;
      rd_value_in = '0;
      status_in   = STAT_OK;
      unique case (op_type'(req_op))
         OP_READ: begin
            if (in_range) begin
               rd_value_in = rd_any;
            end else begin
               status_in = STAT_RANGE;
            end
         end
         OP_INSERT: begin
            if (full) begin
               status_in = STAT_FULL;
            end else begin
               // past the end appends at the current count
               if (!in_range) begin
                  ctl_pos = IDX_W'(count_ff);
               end
               ctl_op   = accept ? CELL_INSERT : CELL_HOLD;
               count_in = count_ff + 1'b1;
            end
         end
         OP_REMOVE: begin
            if (!in_range) begin
               status_in = STAT_RANGE;
            end else begin
               ctl_op   = accept ? CELL_REMOVE : CELL_HOLD;
               count_in = count_ff - 1'b1;
            end
         end
         default: begin
            status_in = STAT_OK;
         end
      endcase
   end

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic [VALUE_W-1:0] left_v, right_v;
      if (g == 0) begin : g_first
         assign left_v = '0;
      end else begin : g_mid_l
         assign left_v = cell_value[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
         assign right_v = '0;
      end else begin : g_mid_r
         assign right_v = cell_value[g+1];
      end
      ilir_cell #(
         .CellIdx  (g),
         .IdxWidth (IDX_W)
      ) u_cell (
         .clock       (clock),
         .ctl_op      (ctl_op),
         .ctl_pos     (ctl_pos),
         .ins_value   (req_value),
         .left_value  (left_v),
         .right_value (right_v),
         .value       (cell_value[g]),
         .rd_data     (cell_rd[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         count_ff     <= count_in;
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rd_value_ff  <= rd_value_in;
         status_ff    <= status_in;
         rsp_count_ff <= count_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_read_value    = rd_value_ff;
   assign rsp_element_count = rsp_count_ff;
   assign rsp_is_empty      = rsp_count_ff == '0;
   assign rsp_status        = status_ff;

   `ILIR_ASSERT(a_count_bound, count_ff <= CNT_W'(CAPACITY), "count exceeds capacity")
   `ILIR_ASSERT_IMPL(a_full_status, rsp_valid && rsp_status == STAT_FULL,
      rsp_element_count == CNT_W'(CAPACITY), "full status with room left")
   `ILIR_ASSERT_NEXT(a_insert_grows, !reset && accept && req_op == OP_INSERT && !full,
      count_ff == $past(count_ff) + 1'b1, "insert did not grow the list")
   `ILIR_ASSERT_IMPL(a_rsp_count, rsp_valid, rsp_element_count == count_ff,
      "reported count differs from stored count")

endmodule

[rtl/core/ilir_cell.sv]
// One list slot: holds a value and shifts toward or away from its neighbors.
`timescale 1ns / 1ps
module ilir_cell
   import ilir_pkg::*;
#(
   parameter int CellIdx  = 0,
   parameter int IdxWidth = POS_W
) (
   input  logic                clock,
   input  cell_op_type         ctl_op,
   input  logic [IdxWidth-1:0] ctl_pos,
   input  logic [VALUE_W-1:0]  ins_value,
   input  logic [VALUE_W-1:0]  left_value,
   input  logic [VALUE_W-1:0]  right_value,
   output logic [VALUE_W-1:0]  value,
   output logic [VALUE_W-1:0]  rd_data
);

   localparam logic [IdxWidth-1:0] MyIdx = IdxWidth'(CellIdx);

   logic [VALUE_W-1:0]  value_ff;
   logic [VALUE_W-1:0]  value_in;

   always_comb begin
      value_in = value_ff;
      case (ctl_op)
         CELL_INSERT: begin
            if (MyIdx > ctl_pos) begin
               value_in = left_value;
            end else if (MyIdx == ctl_pos) begin
               value_in = ins_value;
            end
         end
         CELL_REMOVE: begin
            if (MyIdx >= ctl_pos) begin
               value_in = right_value;
            end
         end
         default: value_in = value_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value   = value_ff;
   assign rd_data = (MyIdx == ctl_pos) ? value_ff : '0;

endmodule
